FILE: hdl/u8d_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
package u8d_pkg;

    localparam int QUE_DEPTH = 6;                    // five held bytes plus the new one
    localparam logic [20:0] ERR_CHAR   = 21'h00003F; // '?'
    localparam logic [20:0] MIN_TWO    = 21'h000080;
    localparam logic [20:0] MIN_THREE  = 21'h000800;
    localparam logic [20:0] MIN_FOUR   = 21'h010000;
    localparam logic [20:0] MAX_PLUS1  = 21'h110000;
    localparam logic [7:0]  LEAD_ED    = 8'hED;
    localparam logic [3:0]  LOW_SURR_HI = 4'hB;      // B0..BF second byte of low half

    typedef logic [QUE_DEPTH-1:0][7:0] byte_vec_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        error_flag;
        logic [2:0]  bytes_used;
        logic        last_of_run;
    } cp_item_t;

    typedef struct packed {
        logic load;   // append the accepted byte
        logic step;   // emit the front result and drop its bytes
    } u8d_cmd_t;

    typedef struct packed {
        logic stop;      // front needs more bytes, nothing to emit
        logic last;      // front result is the last one for this item
        logic out_free;  // output register can take a result
    } u8d_sts_t;

endpackage

FILE: hdl/utf8_to_codepoint_decoder.sv
// UTF-8 byte stream to code point decoder with CESU-8 surrogate pair joining.
//
// Bytes arrive one item at a time on the byte channel; each result item on the
// cp channel carries one code point, an error flag ('?' = 0x3F on error), the
// number of bytes it consumed (6 for a joined CESU-8 pair) and a flag on the
// last result caused by the byte just taken. Up to five bytes of an unfinished
// sequence are held; end_of_string flushes them all. A byte is first written into
// the queue; the controller then emits the front result and drops its bytes, one
// sequence per cycle while the output register is free, until the front needs
// more bytes or the queue empties, and only then takes the next byte. A byte that
// only extends a pending sequence gives no result. A byte after reset needs no
// warm-up.
module utf8_to_codepoint_decoder
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    output logic       cp_valid,
    input  logic       cp_ready,
    output cp_item_t   cp_item
);

    u8d_cmd_t cmd;
    u8d_sts_t sts;

    // sequencing: accept / step / go idle
    u8d_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // byte queue, decoder, output register
    u8d_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .byte_item (byte_item),
        .cp_ready  (cp_ready),
        .cp_valid  (cp_valid),
        .cp_item   (cp_item)
    );

endmodule

FILE: hdl/u8d_datapath.sv
// Byte queue, front decoder and output register of the decoder.
module u8d_datapath
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  u8d_cmd_t   cmd,
    output u8d_sts_t   sts,
    input  byte_item_t byte_item,
    input  logic       cp_ready,
    output logic       cp_valid,
    output cp_item_t   cp_item
);

    typedef struct packed {
        logic [20:0] cp;
        logic        err;
        logic [2:0]  used;
        logic        shortage;
    } dec_t;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // Decode the front of the queue; shortage means later bytes could change it.
    function automatic dec_t decode_front(input byte_vec_t b, input logic [2:0] len);
        dec_t        r;
        logic [20:0] v;
        logic [20:0] minv;
        logic [2:0]  n;
        logic [7:0]  lead_off;
        logic        pair;
        logic        ok;
        r.cp       = ERR_CHAR;
        r.err      = 1'b1;
        r.used     = 3'd1;
        r.shortage = 1'b0;
        if (b[0] < 8'h80)
        begin
            r.cp   = {13'd0, b[0]};
            r.err  = 1'b0;
            return r;
        end
        if (b[0] < 8'hC0 || b[0] > 8'hF7)
            return r;
        if (len < 3'd2)
        begin
            r.shortage = 1'b1;
            return r;
        end
        if (!is_cont(b[1]))
            return r;
        lead_off = b[0] - 8'hC0;
        v    = {9'd0, lead_off[5:0], b[1][5:0]};
        n    = 3'd2;
        minv = MIN_TWO;
        if (b[0] >= 8'hE0)
        begin
            r.used = 3'd2;
            if (len < 3'd3)
            begin
                r.shortage = 1'b1;
                return r;
            end
            if (!is_cont(b[2]))
                return r;
            if (b[0] < 8'hF0)
            begin
                v    = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
                n    = 3'd3;
                minv = MIN_THREE;
                if (v[15:10] == 6'b110110)
                begin
                    // high surrogate: try to join a CESU-8 low half
                    pair = 1'b1;
                    if (len > 3'd3 && b[3] != LEAD_ED)
                        pair = 1'b0;
                    if (len > 3'd4 && b[4][7:4] != LOW_SURR_HI)
                        pair = 1'b0;
                    if (len > 3'd5 && !is_cont(b[5]))
                        pair = 1'b0;
                    if (pair && len < 3'd6)
                        r.shortage = 1'b1;
                    else if (pair)
                    begin
                        v    = MIN_FOUR + {1'b0, v[9:0], b[4][3:0], b[5][5:0]};
                        n    = 3'd6;
                        minv = MIN_FOUR;
                    end
                end
            end
            else
            begin
                r.used = 3'd3;
                if (len < 3'd4)
                begin
                    r.shortage = 1'b1;
                    return r;
                end
                if (!is_cont(b[3]))
                    return r;
                v    = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
                n    = 3'd4;
                minv = MIN_FOUR;
            end
        end
        ok = (v >= minv) && (v < MAX_PLUS1) && (v[20:11] != 10'h01B) &&
             (v[15:1] != 15'h7FFF) && (v[20:5] != 16'h07EE) && (v[20:5] != 16'h07EF);
        r.used = n;
        if (ok)
        begin
            r.cp  = v;
            r.err = 1'b0;
        end
        return r;
    endfunction

    byte_vec_t   que_reg;
    byte_vec_t   que_next;
    logic [2:0]  len_reg;
    logic [2:0]  len_next;
    logic        eos_reg;
    logic        eos_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    cp_item_t    out_reg;
    cp_item_t    out_next;

    dec_t        front;
    dec_t        after;
    logic [2:0]  used;
    logic [2:0]  len_after;
    byte_vec_t   que_shift;
    logic [5:0]  shift_bits;

    always_comb
    begin
        front      = decode_front(que_reg, len_reg);
        used       = (front.used > len_reg) ? len_reg : front.used;
        len_after  = len_reg - used;
        shift_bits = {used, 3'b000};
        que_shift  = que_reg >> shift_bits;
        after      = decode_front(que_shift, len_after);
    end

    assign sts.stop     = front.shortage && !eos_reg;
    assign sts.last     = (len_after == 3'd0) || (!eos_reg && after.shortage);
    assign sts.out_free = !out_valid_reg || cp_ready;

    always_comb
    begin
        que_next       = que_reg;
        len_next       = len_reg;
        eos_next       = eos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !cp_ready;
        if (cmd.load)
        begin
            for (int i = 0; i < QUE_DEPTH; i++)
            begin
                if (len_reg == i[2:0])
                    que_next[i] = byte_item.data_byte;
            end
            len_next = len_reg + 3'd1;
            eos_next = byte_item.end_of_string;
        end
        else if (cmd.step)
        begin
            que_next             = que_shift;
            len_next             = len_after;
            out_next.code_point  = front.cp;
            out_next.error_flag  = front.err;
            out_next.bytes_used  = used;
            out_next.last_of_run = sts.last;
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= 3'd0;
            eos_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            eos_reg       <= eos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        que_reg <= que_next;
        out_reg <= out_next;
    end

    assign cp_valid = out_valid_reg;
    assign cp_item  = out_reg;

endmodule

FILE: hdl/u8d_ctrl.sv
// Controller: takes a byte, then steps out results until the queue waits or empties.
module u8d_ctrl
    import u8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  u8d_sts_t sts,
    output u8d_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        byte_ready = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                byte_ready = 1'b1;
                if (byte_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.stop)
                    state_next = ST_IDLE;
                else if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/u8d_checker.sv
// Port-level checks for the UTF-8 decoder, bound to the top level.
module u8d_checker
    import u8d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_ready,
    input logic       cp_valid,
    input logic       cp_ready,
    input cp_item_t   cp_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_ready |=> cp_valid && $stable(cp_item))
        else $error("result changed while stalled");

    // every error result carries the replacement character
    a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_item.error_flag |-> cp_item.code_point == ERR_CHAR)
        else $error("error result without replacement character");

    // byte count stays in 1..6
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid |-> cp_item.bytes_used != 3'd0 && cp_item.bytes_used != 3'd7)
        else $error("bytes_used out of range");

    // a good joined pair is a supplementary code point
    a_pair_supp: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_item.error_flag && cp_item.bytes_used == 3'd6
        |-> cp_item.code_point[20:16] != 5'd0)
        else $error("joined pair below U+10000");

    // each byte is worked on before the next is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready |=> !byte_ready)
        else $error("byte taken back to back");

endmodule

bind utf8_to_codepoint_decoder u8d_checker u_u8d_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the UTF-8 to code point decoder: random byte streams, scored results.
module tb_top;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT  = 750000;  // far beyond the slowest legal run
    localparam int DRAIN_CYCLES = 150;     // covers the longest ready stall plus a full flush
    localparam int RANDOM_ITEMS = 480;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_item_t byte_item = '0;
    logic       cp_valid;
    logic       cp_ready = 1'b0;
    cp_item_t   cp_item;

    byte_item_t byte_pend_q [$];   // items still to be sent
    cp_item_t   cp_expect_q [$];   // predicted results, oldest first

    // predictor's copy of the held bytes of an unfinished sequence
    logic [7:0] held_b [5];
    int         held_n = 0;

    int fail_count = 0;
    int cycle_cnt  = 0;

    // idle control for both sides
    int send_gap  = 0;
    bit send_calm = 1'b0;
    int recv_hold = 0;
    bit recv_calm = 1'b0;

    // scratch sequence for the random generator
    logic [7:0] seq_buf [16];
    int         seq_n;

    utf8_to_codepoint_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_item    (cp_item)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // in range, not a surrogate, not a noncharacter
    function automatic bit scalar_ok(input logic [31:0] v);
        return v < 32'(MAX_PLUS1) && (v - 32'hD800) > 32'h7FF &&
               v[15:0] < 16'hFFFE && (v - 32'hFDD0) > 32'h1F;
    endfunction

    // Decode the sequence at the front of s[0..len). need_more is raised when
    // a later byte could still change the answer.
    function automatic void decode_front(input logic [7:0] s [6], input int len,
                                         output logic [31:0] cp, output bit err,
                                         output int used, output bit need_more);
        logic [7:0]  lead;
        logic [7:0]  low_mid;
        logic [31:0] v;
        logic [31:0] minv;
        int          n;
        bit          pair;
        lead      = s[0];
        need_more = 1'b0;
        cp        = 32'(ERR_CHAR);
        err       = 1'b1;
        used      = 1;
        if (lead < 8'h80)
        begin
            cp  = 32'(lead);
            err = 1'b0;
            return;
        end
        // stray continuation or F8..FF lead
        if (lead < 8'hC0 || lead > 8'hF7)
            return;
        if (len < 2)
        begin
            need_more = 1'b1;
            return;
        end
        if (!is_cont(s[1]))
            return;
        v    = ((32'(lead) - 32'hC0) << 6) | 32'(s[1][5:0]);
        n    = 2;
        minv = 32'h80;
        if (lead >= 8'hE0)
        begin
            used = 2;
            if (len < 3)
            begin
                need_more = 1'b1;
                return;
            end
            if (!is_cont(s[2]))
                return;
            if (lead < 8'hF0)
            begin
                v    = (32'(lead[3:0]) << 12) | (32'(s[1][5:0]) << 6) | 32'(s[2][5:0]);
                n    = 3;
                minv = 32'h800;
                // high surrogate: try to join with a following low half
                if ((v - 32'hD800) < 32'h400)
                begin
                    pair    = 1'b1;
                    low_mid = s[4] - 8'hB0;
                    if (len > 3 && s[3] != LEAD_ED)
                        pair = 1'b0;
                    if (pair && len > 4 && low_mid >= 8'h10)
                        pair = 1'b0;
                    if (pair && len > 5 && !is_cont(s[5]))
                        pair = 1'b0;
                    if (pair && len < 6)
                        need_more = 1'b1;
                    else if (pair)
                    begin
                        v    = 32'h10000 + ((v - 32'hD800) << 10) +
                               (32'(low_mid) << 6) + 32'(s[5][5:0]);
                        n    = 6;
                        minv = 32'h10000;
                    end
                end
            end
            else
            begin
                used = 3;
                if (len < 4)
                begin
                    need_more = 1'b1;
                    return;
                end
                if (!is_cont(s[3]))
                    return;
                v    = (32'(lead[2:0]) << 18) | (32'(s[1][5:0]) << 12) |
                       (32'(s[2][5:0]) << 6) | 32'(s[3][5:0]);
                n    = 4;
                minv = 32'h10000;
            end
        end
        used = n;
        if (v >= minv && scalar_ok(v))
        begin
            cp  = v;
            err = 1'b0;
        end
    endfunction

    // Work out every result the accepted byte causes and queue them.
    function automatic void predict_bytes(input byte_item_t it);
        logic [7:0]  s [6];
        cp_item_t    runs [6];
        logic [31:0] cp;
        bit          err;
        bit          need_more;
        int          used;
        int          len;
        int          k;
        for (int i = 0; i < 6; i++)
            s[i] = 8'h00;
        for (int i = 0; i < held_n; i++)
            s[i] = held_b[i];
        len    = held_n;
        s[len] = it.data_byte;
        len++;
        k = 0;
        while (len > 0 && k < 6)
        begin
            decode_front(s, len, cp, err, used, need_more);
            if (need_more && !it.end_of_string)
                break;
            if (used > len)
                used = len;
            runs[k].code_point  = cp[20:0];
            runs[k].error_flag  = err;
            runs[k].bytes_used  = used[2:0];
            runs[k].last_of_run = 1'b0;
            k++;
            for (int i = 0; i < 6; i++)
                s[i] = (i + used < 6) ? s[i + used] : 8'h00;
            len -= used;
        end
        if (k > 0)
            runs[k - 1].last_of_run = 1'b1;
        for (int i = 0; i < k; i++)
            cp_expect_q.push_back(runs[i]);
        if (len > 5)
            len = 5;
        for (int i = 0; i < len; i++)
            held_b[i] = s[i];
        held_n = len;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input bit eos);
        byte_item_t it;
        it.data_byte     = b;
        it.end_of_string = eos;
        byte_pend_q.push_back(it);
    endtask

    // Encode cp in a form of len bytes; a short value in a long form gives
    // an overlong, and wide values give F5..F7 leads.
    task automatic enc(input logic [31:0] c, input int len);
        case (len)
            1:
            begin
                seq_buf[seq_n] = {1'b0, c[6:0]};
                seq_n += 1;
            end
            2:
            begin
                seq_buf[seq_n]     = {3'b110, c[10:6]};
                seq_buf[seq_n + 1] = {2'b10, c[5:0]};
                seq_n += 2;
            end
            3:
            begin
                seq_buf[seq_n]     = {4'b1110, c[15:12]};
                seq_buf[seq_n + 1] = {2'b10, c[11:6]};
                seq_buf[seq_n + 2] = {2'b10, c[5:0]};
                seq_n += 3;
            end
            default:
            begin
                seq_buf[seq_n]     = {5'b11110, c[20:18]};
                seq_buf[seq_n + 1] = {2'b10, c[17:12]};
                seq_buf[seq_n + 2] = {2'b10, c[11:6]};
                seq_buf[seq_n + 3] = {2'b10, c[5:0]};
                seq_n += 4;
            end
        endcase
    endtask

    // One random sequence: mostly well formed with random content, some
    // invalid values, some noise, and a share broken or cut short.
    task automatic gen_random_seq();
        int unsigned pick;
        int unsigned sel;
        logic [31:0] c;
        int          len;
        seq_n = 0;
        pick  = $urandom_range(0, 99);
        sel   = $urandom_range(0, 4);
        if (pick < 12)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                seq_buf[seq_n] = 8'($urandom_range(0, 255));
                seq_n += 1;
            end
        end
        else if (pick < 27)
            enc($urandom_range(0, 32'h7F), 1);
        else if (pick < 39)
            enc($urandom_range(32'h80, 32'h7FF), 2);
        else if (pick < 54)
        begin
            case (sel)
                0: c = 32'hFFFE + $urandom_range(0, 1);
                1: c = 32'hFDD0 + $urandom_range(0, 31);
                default: c = $urandom_range(32'h800, 32'hFFFF);
            endcase
            enc(c, 3);
        end
        else if (pick < 66)
        begin
            case (sel)
                0: c = 32'h110000 + $urandom_range(0, 32'hEFFFF);
                1: c = ($urandom_range(1, 16) << 16) + 32'hFFFE + $urandom_range(0, 1);
                default: c = $urandom_range(32'h10000, 32'h10FFFF);
            endcase
            enc(c, 4);
        end
        else if (pick < 82)
        begin
            // CESU-8 pair, sometimes one that lands on a noncharacter
            if (sel == 0)
                c = ($urandom_range(1, 16) << 16) + 32'hFFFE + $urandom_range(0, 1);
            else
                c = $urandom_range(32'h10000, 32'h10FFFF);
            c = c - 32'h10000;
            enc(32'hD800 + (c >> 10), 3);
            enc(32'hDC00 + (c & 32'h3FF), 3);
        end
        else if (pick < 91)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2: c = $urandom_range(0, 32'h7F);
                3: c = $urandom_range(0, 32'h7FF);
                default: c = $urandom_range(0, 32'hFFFF);
            endcase
            enc(c, len);
        end
        else
            enc($urandom_range(32'hD800, 32'hDFFF), 3);

        // break some sequences: a bad byte inside, or cut short
        if (seq_n > 1 && $urandom_range(0, 9) == 0)
            seq_buf[$urandom_range(1, seq_n - 1)] = 8'($urandom_range(0, 255));
        else if (seq_n > 1 && $urandom_range(0, 14) == 0)
            seq_n = $urandom_range(1, seq_n - 1);

        // end of string mostly at a sequence end, rarely in the middle
        for (int i = 0; i < seq_n; i++)
            queue_byte(seq_buf[i], (i == seq_n - 1) ? ($urandom_range(0, 9) == 0)
                                                    : ($urandom_range(0, 49) == 0));
    endtask

    // Idle length: mostly none or short, a few long; calm stretches give none.
    function automatic int pick_gap(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        if (fail_count <= 200)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Driver: feeds the byte channel from the pending queue. An item is
    // scored in the predictor at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        bit next_valid;
        if (rst_n && (!byte_valid || byte_ready))
        begin
            if (byte_valid)
                predict_bytes(byte_item);
            next_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (byte_pend_q.size() > 0)
            begin
                next_valid = 1'b1;
                byte_item <= byte_pend_q.pop_front();
                if ($urandom_range(0, 59) == 0)
                    send_calm = ~send_calm;
                send_gap = pick_gap(send_calm);
            end
            byte_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: scores each accepted result against the oldest prediction
    // and throttles cp_ready.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : cp_monitor
        cp_item_t want;
        if (rst_n)
        begin
            if (cp_valid && cp_ready)
            begin
                if (cp_expect_q.size() == 0)
                    report_mismatch("result with nothing expected, code_point",
                                    32'(cp_item.code_point), 0);
                else
                begin
                    want = cp_expect_q.pop_front();
                    if (cp_item.code_point !== want.code_point)
                        report_mismatch("code_point", 32'(cp_item.code_point),
                                        32'(want.code_point));
                    if (cp_item.error_flag !== want.error_flag)
                        report_mismatch("error_flag", 32'(cp_item.error_flag),
                                        32'(want.error_flag));
                    if (cp_item.bytes_used !== want.bytes_used)
                        report_mismatch("bytes_used", 32'(cp_item.bytes_used),
                                        32'(want.bytes_used));
                    if (cp_item.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(cp_item.last_of_run),
                                        32'(want.last_of_run));
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                cp_ready <= 1'b0;
            end
            else
            begin
                cp_ready <= 1'b1;
                if ($urandom_range(0, 79) == 0)
                    recv_calm = ~recv_calm;
                if ($urandom_range(0, 99) < 30)
                    recv_hold = pick_gap(recv_calm);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim_main
        int target;
        // directed: ASCII and bad-lead extremes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        // overlong two-byte form
        queue_byte(8'hC0, 1'b0); queue_byte(8'h80, 1'b0);
        // bad second byte, then bad third byte (the ASCII after is decoded again)
        queue_byte(8'hE2, 1'b0); queue_byte(8'h41, 1'b0);
        queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'h7F, 1'b0);
        // above U+10FFFF
        queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0); queue_byte(8'h80, 1'b0);
        // joined CESU-8 pair, smallest supplementary value
        queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hED, 1'b0); queue_byte(8'hB0, 1'b0); queue_byte(8'h80, 1'b0);
        // high surrogate not followed by a low half
        queue_byte(8'hED, 1'b0); queue_byte(8'hAF, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // four-byte form cut short by end of string
        queue_byte(8'hF0, 1'b0); queue_byte(8'h90, 1'b1);

        target = byte_pend_q.size() + RANDOM_ITEMS;
        while (byte_pend_q.size() < target)
            gen_random_seq();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // all items sent and every predicted result seen
        while (byte_pend_q.size() != 0 || byte_valid || cp_expect_q.size() != 0)
            @(posedge clk);
        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && cp_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/u8d_pkg.sv
hdl/u8d_datapath.sv
hdl/u8d_ctrl.sv
hdl/utf8_to_codepoint_decoder.sv
hdl/u8d_checker.sv
bench/tb_top.sv
